### hw/rtl/bwae_pkg.sv
// shared types and constants of the bit set word algebra enumerator
package bwae_pkg;

   // fixed field widths
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam int ELEM_W    = 11;
   localparam int SIZE_W    = 12;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2048);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENUMERATE = 2'd2;

   // set operations
   typedef enum logic [1:0] {
      OP_PASS      = 2'd0,
      OP_UNION     = 2'd1,
      OP_INTERSECT = 2'd2,
      OP_SUBTRACT  = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WORD    = 2'd0,
      KIND_INDEX   = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WORD = 2'd1,
      ST_SCAN = 2'd2,
      ST_SUM  = 2'd3
   } state_type;

   // run summary flags
   typedef struct packed {
      logic equal;
      logic disjoint;
      logic subset;
      logic empty;
   } flags_type;

   localparam flags_type FLAGS_CLEAR = '{equal: 1'b1, disjoint: 1'b1, subset: 1'b1, empty: 1'b1};
   localparam flags_type FLAGS_NONE  = '{equal: 1'b0, disjoint: 1'b0, subset: 1'b0, empty: 1'b0};

endpackage

### hw/rtl/bwae_if.sv
// request and response channel interfaces
interface bwae_req_if;
   import bwae_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] a_word;
   logic [WORD_BITS-1:0] b_word;
   logic                 last;

   modport source (output valid, output a_word, output b_word, output last, input ready);
   modport sink (input valid, input a_word, input b_word, input last, output ready);
endinterface

interface bwae_rsp_if;
   import bwae_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [WORD_BITS-1:0] result_word;
   logic [ELEM_W-1:0]    element_index;
   logic                 sets_equal;
   logic                 sets_disjoint;
   logic                 first_subset;
   logic                 result_empty;
   logic                 run_end;

   modport source (output valid, output kind, output result_word, output element_index,
                   output sets_equal, output sets_disjoint, output first_subset,
                   output result_empty, output run_end, input ready);
   modport sink (input valid, input kind, input result_word, input element_index,
                 input sets_equal, input sets_disjoint, input first_subset,
                 input result_empty, input run_end, output ready);
endinterface

### hw/rtl/bitset_word_algebra_enumerator_core.sv
// Flow: the combined word of a taken transaction is registered, then issued from the output
// register; with enumeration a bit-serial scan then tests one bit per cycle, holding while the
// output is stalled, up to the highest set bit, one index out per set bit, and a last
// transaction adds a summary. A new transaction is taken only once the previous one is done.
// Reset: synchronous, clears sequencer, run position, flags and output valid; CSRs to defaults.
module bitset_word_algebra_enumerator_core #(
   parameter int MAX_WORDS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bwae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bwae_pkg::SIZE_W-1:0]       csr_wdata,
   bwae_req_if.sink                          req_chan,
   bwae_rsp_if.source                        rsp_chan
);
   import bwae_pkg::*;

   localparam int POS_W = $clog2(MAX_WORDS + 1);

   // configuration registers
   op_type            op_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              enum_ff;

   // sequencer and run state
   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   flags_type         flags_ff, flags_in;

   // item working registers
   logic [WORD_BITS-1:0] comb_ff, comb_in;
   logic [WORD_BITS-1:0] shift_ff, shift_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [ELEM_W-1:0]    base_ff, base_in;
   logic                 last_ff, last_in;
   logic                 enum_run_ff, enum_run_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic [ELEM_W-1:0]    rsp_index_ff, rsp_index_in;
   flags_type            rsp_flags_ff, rsp_flags_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic [WORD_BITS-1:0] comb_w;
   flags_type            word_flags;
   logic [WORD_BITS-1:0] shift_next;
   logic                 slot_free;

   bwae_combine #(
      .MAX_WORDS (MAX_WORDS),
      .POS_W     (POS_W)
   ) u_combine (
      .operation  (op_ff),
      .set_size   (size_ff),
      .pos        (pos_ff),
      .a_in       (req_chan.a_word),
      .b_in       (req_chan.b_word),
      .comb       (comb_w),
      .word_flags (word_flags)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= OP_UNION;
         size_ff <= SIZE_RESET;
         enum_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPERATION: op_ff   <= op_type'(csr_wdata[1:0]);
            CSR_SET_SIZE:  size_ff <= csr_wdata;
            CSR_ENUMERATE: enum_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign shift_next = shift_ff >> 1;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      flags_in     = flags_ff;
      comb_in      = comb_ff;
      shift_in     = shift_ff;
      bit_in       = bit_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      enum_run_in  = enum_run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_end_in   = rsp_end_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         // take the word pair and fold its relations into the run flags
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               comb_in     = comb_w;
               flags_in    = flags_type'(flags_ff & word_flags);
               last_in     = req_chan.last;
               enum_run_in = enum_ff;
               base_in     = ELEM_W'({pos_ff, BIT_W'(0)});
               if (!req_chan.last && (pos_ff < POS_W'(MAX_WORDS))) begin
                  pos_in = POS_W'(pos_ff + 1'b1);
               end
               state_in = ST_WORD;
            end
         end
         // combined word transaction
         ST_WORD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WORD;
               rsp_word_in  = comb_ff;
               rsp_index_in = '0;
               rsp_flags_in = FLAGS_NONE;
               rsp_end_in   = !last_ff && (!enum_run_ff || (comb_ff == '0));
               shift_in     = comb_ff;
               bit_in       = '0;
               if (enum_run_ff && (comb_ff != '0)) begin
                  state_in = ST_SCAN;
               end else if (last_ff) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         // bit-serial scan, one index per set bit
         ST_SCAN: begin
            if (!shift_ff[0]) begin
               shift_in = shift_next;
               bit_in   = BIT_W'(bit_ff + 1'b1);
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_INDEX;
               rsp_word_in  = '0;
               rsp_index_in = {base_ff[ELEM_W-1:BIT_W], bit_ff};
               rsp_flags_in = FLAGS_NONE;
               rsp_end_in   = !last_ff && (shift_next == '0);
               shift_in     = shift_next;
               bit_in       = BIT_W'(bit_ff + 1'b1);
               if (shift_next == '0) begin
                  state_in = last_ff ? ST_SUM : ST_IDLE;
               end
            end
         end
         // end summary, then the run starts over
         ST_SUM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SUMMARY;
               rsp_word_in  = '0;
               rsp_index_in = '0;
               rsp_flags_in = flags_ff;
               rsp_end_in   = 1'b1;
               pos_in       = '0;
               flags_in     = FLAGS_CLEAR;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         flags_ff     <= FLAGS_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      comb_ff      <= comb_in;
      shift_ff     <= shift_in;
      bit_ff       <= bit_in;
      base_ff      <= base_in;
      last_ff      <= last_in;
      enum_run_ff  <= enum_run_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // response port
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.result_word   = rsp_word_ff;
   assign rsp_chan.element_index = rsp_index_ff;
   assign rsp_chan.sets_equal    = rsp_flags_ff.equal;
   assign rsp_chan.sets_disjoint = rsp_flags_ff.disjoint;
   assign rsp_chan.first_subset  = rsp_flags_ff.subset;
   assign rsp_chan.result_empty  = rsp_flags_ff.empty;
   assign rsp_chan.run_end       = rsp_end_ff;

   // a new transaction only starts once the previous one has handed over its final result
   a_accept_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && rsp_valid_ff) |-> rsp_end_ff)
      else $error("transaction accepted before previous run_end");

   // word position saturates at the maximum
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_WORDS))
      else $error("word position beyond maximum");

   // issuing the summary returns the run state to its start
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && slot_free) |=> (pos_ff == '0 && flags_ff == FLAGS_CLEAR))
      else $error("run state not cleared after summary");

   // a summary always closes its transaction
   a_summary_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_SUMMARY) |-> rsp_end_ff)
      else $error("summary without run_end");

endmodule

### hw/rtl/bwae_combine.sv
// masking of one word pair, set operation and per-word relation flags
module bwae_combine #(
   parameter int MAX_WORDS = 64,
   parameter int POS_W     = 7
) (
   input  bwae_pkg::op_type                    operation,
   input  logic [bwae_pkg::SIZE_W-1:0]         set_size,
   input  logic [POS_W-1:0]                    pos,
   input  logic [bwae_pkg::WORD_BITS-1:0]      a_in,
   input  logic [bwae_pkg::WORD_BITS-1:0]      b_in,
   output logic [bwae_pkg::WORD_BITS-1:0]      comb,
   output bwae_pkg::flags_type                 word_flags
);
   import bwae_pkg::*;

   localparam int START_W = POS_W + BIT_W;
   localparam int CALC_W  = ((START_W > SIZE_W) ? START_W : SIZE_W) + 1;
   localparam logic [CALC_W-1:0] LIMIT = CALC_W'(MAX_WORDS * WORD_BITS);

   logic [CALC_W-1:0]    size_c;
   logic [CALC_W-1:0]    start;
   logic [CALC_W-1:0]    rem;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] a_m;
   logic [WORD_BITS-1:0] b_m;

   // clamp the set size and find the valid bits of this word
   always_comb begin
      size_c = (CALC_W'(set_size) > LIMIT) ? LIMIT : CALC_W'(set_size);
      start  = CALC_W'({pos, BIT_W'(0)});
      rem    = size_c - start;
      mask   = '0;
      if ((pos < POS_W'(MAX_WORDS)) && (size_c > start)) begin
         for (int k = 0; k < WORD_BITS; k++) begin
            mask[k] = (CALC_W'(k) < rem);
         end
      end
   end

   assign a_m = a_in & mask;
   assign b_m = b_in & mask;

   // set operation
   always_comb begin
      case (operation)
         OP_PASS:      comb = a_m;
         OP_UNION:     comb = a_m | b_m;
         OP_INTERSECT: comb = a_m & b_m;
         OP_SUBTRACT:  comb = a_m & ~b_m;
         default:      comb = a_m;
      endcase
   end

   // relations of this word pair
   assign word_flags.equal    = (a_m == b_m);
   assign word_flags.disjoint = ((a_m & b_m) == '0);
   assign word_flags.subset   = ((a_m & ~b_m) == '0);
   assign word_flags.empty    = (comb == '0);

endmodule

### tb/tb.sv
// self-checking testbench for the bit set word algebra enumerator core
`timescale 1ns / 100ps

module tb;
   import bwae_pkg::*;

   localparam int MAX_WORDS     = 64;
   localparam int MAX_ELEMS     = MAX_WORDS * WORD_BITS;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 49;
   localparam int SETTLE_CYCLES = 48;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int MAX_REPORTS   = 10;

   // content patterns of a word pair run
   typedef enum int {
      MIX_RANDOM,
      MIX_EQUAL,
      MIX_SUBSET,
      MIX_DISJOINT,
      MIX_SPARSE,
      MIX_EXTREME
   } mix_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
      logic                 last;
   } word_pair_type;

   typedef struct packed {
      kind_type             kind;
      logic [WORD_BITS-1:0] word;
      logic [ELEM_W-1:0]    elem;
      flags_type            flags;
      logic                 run_end;
   } result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   bwae_req_if req_if ();
   bwae_rsp_if rsp_if ();

   bitset_word_algebra_enumerator_core #(.MAX_WORDS(MAX_WORDS)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // word pairs waiting to be sent and results still due from the core
   word_pair_type pairs_pending[$];
   word_pair_type pair_on_bus;
   result_type    results_due[$];

   // local copy of the registers and of the run state
   op_type            cfg_op;
   logic [SIZE_W-1:0] cfg_size;
   logic              cfg_enum;
   logic [6:0]        run_pos;
   flags_type         run_flags;

   int          send_pct;
   int          rcv_pct;
   int unsigned errors;
   int unsigned cycles;
   int unsigned pairs_sent;
   int unsigned results_seen;
   int unsigned indexes_seen;
   int unsigned summaries_seen;
   int unsigned settings_used;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // combine one word pair and queue the results it must produce
   function automatic void combine_word_pair(logic [WORD_BITS-1:0] a_in,
                                             logic [WORD_BITS-1:0] b_in, logic last_in);
      int unsigned          limit, start, rem, total, seen;
      logic [WORD_BITS-1:0] mask, a, b, comb;
      result_type           r;
      mask  = '0;
      limit = (cfg_size > MAX_ELEMS) ? MAX_ELEMS : cfg_size;
      start = run_pos * WORD_BITS;
      if (run_pos < MAX_WORDS && limit > start) begin
         rem  = limit - start;
         mask = (rem >= WORD_BITS) ? {WORD_BITS{1'b1}} : (WORD_BITS'(1) << rem) - 1'b1;
      end
      a = a_in & mask;
      b = b_in & mask;
      case (cfg_op)
         OP_PASS:      comb = a;
         OP_UNION:     comb = a | b;
         OP_INTERSECT: comb = a & b;
         default:      comb = a & ~b;
      endcase
      if (a != b) run_flags.equal = 1'b0;
      if ((a & b) != 0) run_flags.disjoint = 1'b0;
      if ((a & ~b) != 0) run_flags.subset = 1'b0;
      if (comb != 0) run_flags.empty = 1'b0;

      total = cfg_enum ? $countones(comb) : 0;
      seen  = 0;
      r = '{kind: KIND_WORD, word: comb, elem: '0, flags: FLAGS_NONE,
            run_end: !last_in && total == 0};
      results_due.push_back(r);
      // element indexes in ascending order
      if (cfg_enum) begin
         for (int k = 0; k < WORD_BITS; k++) begin
            if (comb[k]) begin
               seen++;
               r = '{kind: KIND_INDEX, word: '0, elem: ELEM_W'(start + k), flags: FLAGS_NONE,
                     run_end: !last_in && seen == total};
               results_due.push_back(r);
            end
         end
      end
      // run summary closes the run
      if (last_in) begin
         r = '{kind: KIND_SUMMARY, word: '0, elem: '0, flags: run_flags, run_end: 1'b1};
         results_due.push_back(r);
         run_pos   = '0;
         run_flags = FLAGS_CLEAR;
      end else if (run_pos < MAX_WORDS) begin
         run_pos++;
      end
   endfunction

   function automatic string describe(result_type r);
      return $sformatf("kind %0d word %h index %0d flags %b end %b",
                       r.kind, r.word, r.elem, r.flags, r.run_end);
   endfunction

   task automatic report_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("error at cycle %0d: %s", cycles, msg);
   endtask

   function automatic void push_pair(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                                     logic last);
      word_pair_type p;
      p = '{a: a, b: b, last: last};
      pairs_pending.push_back(p);
   endfunction

   // wait until the core has delivered every result and gone quiet
   task automatic settle();
      do @(negedge clock);
      while (pairs_pending.size() != 0 || req_if.valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic write_cfg(op_type op, logic [SIZE_W-1:0] size, logic en);
      settle();
      write_reg(CSR_OPERATION, SIZE_W'(op));
      write_reg(CSR_SET_SIZE, size);
      write_reg(CSR_ENUMERATE, SIZE_W'(en));
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_op   = op;
      cfg_size = size;
      cfg_enum = en;
      settings_used++;
   endtask

   // driver: present word pairs, predict on each accepted transaction
   always @(posedge clock) begin : driver
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            combine_word_pair(pair_on_bus.a, pair_on_bus.b, pair_on_bus.last);
            pairs_sent++;
         end
         if (pairs_pending.size() != 0 && !(send_pct != 0 && $urandom_range(99) < send_pct))
         begin
            pair_on_bus = pairs_pending.pop_front();
            req_if.valid  <= 1'b1;
            req_if.a_word <= pair_on_bus.a;
            req_if.b_word <= pair_on_bus.b;
            req_if.last   <= pair_on_bus.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result transaction with the oldest one due
   always @(posedge clock) begin : monitor
      result_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{kind: kind_type'(rsp_if.kind), word: rsp_if.result_word,
                    elem: rsp_if.element_index,
                    flags: {rsp_if.sets_equal, rsp_if.sets_disjoint,
                            rsp_if.first_subset, rsp_if.result_empty},
                    run_end: rsp_if.run_end};
            results_seen++;
            if (got.kind == KIND_INDEX) indexes_seen++;
            if (got.kind == KIND_SUMMARY) summaries_seen++;
            if (results_due.size() == 0) begin
               report_error({"unexpected result: ", describe(got)});
            end else begin
               want = results_due.pop_front();
               if (got !== want)
                  report_error({"expected ", describe(want), ", got ", describe(got)});
            end
         end
         rsp_if.ready <= !(rcv_pct != 0 && $urandom_range(99) < rcv_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles with %0d results due", cycles, results_due.size());
         $display("** bitset_word_algebra_enumerator_core: FAILED **");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      logic [SIZE_W-1:0]    size_pick[PHASES];
      logic [SIZE_W-1:0]    dir_size[4];
      logic [WORD_BITS-1:0] rnd_a, rnd_b;
      int unsigned          made, run_len, pick;
      mix_type              mix;

      size_pick = '{12'd2048, 12'd4095, 12'd0, 12'd1, 12'd33, 12'd200, 12'd2047, 12'd100};
      dir_size  = '{12'd2048, 12'd33, 12'd4095, 12'd1};
      csr_we        = 1'b0;
      csr_index     = CSR_OPERATION;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.a_word = '0;
      req_if.b_word = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      send_pct      = 0;
      rcv_pct       = 0;
      cfg_op        = OP_UNION;
      cfg_size      = SIZE_RESET;
      cfg_enum      = 1'b1;
      run_pos       = '0;
      run_flags     = FLAGS_CLEAR;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, empty, full and disjoint sets
      push_pair('0, '0, 1'b1);
      push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_pair('0, 32'hFFFF_FFFF, 1'b0);
      push_pair(32'hFFFF_FFFF, '0, 1'b1);

      // directed: every operation, with partial, oversized and tiny set sizes
      for (int k = 0; k < 4; k++) begin
         write_cfg(op_type'(k), dir_size[k], 1'b1);
         push_pair(32'hF0F0_1234, 32'h0FF0_8001, 1'b0);
         push_pair(32'h8000_0001, 32'hFFFF_FFFF, 1'b1);
      end

      // directed: zero set size, enumeration off, settings changed inside a run
      write_cfg(OP_UNION, 12'd0, 1'b1);
      push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      write_cfg(OP_UNION, 12'd2048, 1'b0);
      push_pair(32'hA5A5_5A5A, 32'h0000_FFFF, 1'b1);
      write_cfg(OP_INTERSECT, 12'd2048, 1'b1);
      push_pair(32'h0000_00FF, 32'h0000_000F, 1'b0);
      write_cfg(OP_SUBTRACT, 12'd64, 1'b1);
      push_pair(32'h0000_0003, 32'h0000_0001, 1'b1);

      // random phases, each with its own settings and idling
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1) size_pick[ph] = SIZE_W'($urandom_range(1, MAX_ELEMS));
         write_cfg(op_type'((ph + ph / 4) % 4), size_pick[ph], !(ph == 2 || ph == 5));
         case (ph % 4)
            0: begin send_pct = 0;  rcv_pct = 0;  end
            1: begin send_pct = 76; rcv_pct = 0;  end
            2: begin send_pct = 0;  rcv_pct = 76; end
            default: begin send_pct = 13; rcv_pct = 13; end
         endcase
         made = 0;
         while (made < PHASE_ITEMS) begin
            pick    = $urandom_range(99);
            run_len = (pick < 70) ? $urandom_range(1, 6) :
                      (pick < 92) ? $urandom_range(7, 40) : $urandom_range(60, 70);
            mix     = mix_type'($urandom_range(5));
            // a run cut by the phase end carries on under the next settings
            for (int w = 1; w <= run_len && made < PHASE_ITEMS; w++) begin
               rnd_a = $urandom;
               rnd_b = $urandom;
               case (mix)
                  MIX_EQUAL:    rnd_b = rnd_a;
                  MIX_SUBSET:   rnd_a = rnd_a & rnd_b;
                  MIX_DISJOINT: rnd_b = rnd_b & ~rnd_a;
                  MIX_SPARSE: begin
                     rnd_a = ($urandom_range(2) == 0) ? '0 : WORD_BITS'(1) << $urandom_range(31);
                     rnd_b = ($urandom_range(2) == 0) ? '0 : WORD_BITS'(1) << $urandom_range(31);
                  end
                  MIX_EXTREME: begin
                     rnd_a = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                     rnd_b = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                  end
                  default: ;
               endcase
               push_pair(rnd_a, rnd_b, w == run_len);
               made++;
            end
         end
      end

      settle();
      $display("covered %0d word pair transactions under %0d settings", pairs_sent,
               settings_used);
      $display("checked %0d results: %0d element indexes, %0d run summaries, %0d errors",
               results_seen, indexes_seen, summaries_seen, errors);
      if (errors == 0) begin
         $display("** bitset_word_algebra_enumerator_core: PASSED **");
      end else begin
         $display("** bitset_word_algebra_enumerator_core: FAILED **");
      end
      $finish;
   end

endmodule
